### sv/tlbc_pkg.sv
// Package with constants, mode codes and arithmetic helpers of the blend compositor.
`default_nettype none
package tlbc_pkg;
  localparam int HwLayers = 3;
  localparam int DefaultNumLayers = 3;
  localparam int Channels = 3;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_DARKEN = 3'd2,
    MODE_LIGHTEN = 3'd3,
    MODE_DIFFERENCE = 3'd4,
    MODE_GLOW = 3'd5,
    MODE_OVERLAY = 3'd6
  } mode_t;

  localparam logic [2:0] REG_LAYER0_MODE = 3'd0;
  localparam logic [2:0] REG_LAYER1_MODE = 3'd1;
  localparam logic [2:0] REG_LAYER2_MODE = 3'd2;
  localparam logic [2:0] REG_LAYER0_ALPHA = 3'd3;
  localparam logic [2:0] REG_LAYER1_ALPHA = 3'd4;
  localparam logic [2:0] REG_LAYER2_ALPHA = 3'd5;

  typedef logic [7:0] chan_t;
  typedef chan_t [Channels-1:0] pix_t;

  // Floor of x / 255 for x < 65280 by reciprocal multiply and one correction.
  function automatic chan_t div255(input logic [15:0] x);
    logic [16:0] q;
    logic [16:0] r;
    begin
      q = 17'((32'(x) * 32'd257) >> 16);
      r = 17'(x) - 17'(q[8:0]) * 17'd255;
      if (r >= 17'd255) begin
        q = q + 17'd1;
      end
      div255 = q[7:0];
    end
  endfunction
endpackage
`default_nettype wire

### sv/tlbc_layer.sv
// One layer stage: seven pipeline steps, with the glow quotient from a four-step restoring divider.
`default_nettype none
module tlbc_layer
  import tlbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic enable,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] alpha,
  input  wire logic in_valid,
  input  wire pix_t fg,
  input  wire pix_t back,
  output logic out_valid,
  output pix_t result
);
  localparam int QW = 16;

  // Step 1 registers: products and operands.
  logic v1;
  pix_t f1, b1;
  logic [Channels-1:0][15:0] fb1, inv1, bb1;
  // Step 2..: glow division lanes, 16 quotient bits over 4 steps of 4 bits.
  logic [3:0] vq;
  pix_t fq [5];
  pix_t bq [5];
  logic [Channels-1:0][15:0] fbq [5];
  logic [Channels-1:0][15:0] invq [5];
  logic [Channels-1:0][15:0] numq [5];
  logic [Channels-1:0][15:0] quoq [5];
  logic [Channels-1:0][8:0] remq [5];
  // Blend result stage.
  logic v6;
  pix_t g6, b6;
  logic [Channels-1:0][15:0] ag6, nb6;
  logic v7;
  pix_t r7;
  mode_t md;

  assign md = mode_t'(mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vq <= '0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= in_valid;
      vq <= {vq[2:0], v1};
      v6 <= vq[3];
      v7 <= v6;
    end
    f1 <= fg;
    b1 <= back;
    for (int c = 0; c < Channels; c++) begin
      fb1[c] <= 16'(fg[c]) * 16'(back[c]);
      inv1[c] <= 16'(8'd255 - fg[c]) * 16'(8'd255 - back[c]);
      bb1[c] <= 16'(back[c]) * 16'(back[c]);
    end
  end

  always_comb begin
    fq[0] = f1;
    bq[0] = b1;
    fbq[0] = fb1;
    invq[0] = inv1;
    numq[0] = bb1;
    quoq[0] = '0;
    for (int c = 0; c < Channels; c++) begin
      remq[0][c] = '0;
    end
  end

  for (genvar s = 0; s < 4; s++) begin : g_div
    always_ff @(posedge clk) begin
      fq[s+1] <= fq[s];
      bq[s+1] <= bq[s];
      fbq[s+1] <= fbq[s];
      invq[s+1] <= invq[s];
      for (int c = 0; c < Channels; c++) begin
        logic [8:0] r;
        logic [15:0] n;
        logic [15:0] q;
        logic [8:0] d;
        r = remq[s][c];
        n = numq[s][c];
        q = quoq[s][c];
        d = 9'(8'd255 - fq[s][c]);
        for (int k = 0; k < 4; k++) begin
          logic [9:0] t;
          t = {r, n[QW-1]};
          n = {n[QW-2:0], 1'b0};
          if (d != 9'd0 && t >= 10'(d)) begin
            t = t - 10'(d);
            q = {q[QW-2:0], 1'b1};
          end else begin
            q = {q[QW-2:0], 1'b0};
          end
          r = t[8:0];
        end
        remq[s+1][c] <= r;
        numq[s+1][c] <= n;
        quoq[s+1][c] <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < Channels; c++) begin
      logic [7:0] f, b, g;
      f = fq[4][c];
      b = bq[4][c];
      case (md)
        MODE_MULTIPLY: g = fbq[4][c][15:8];
        MODE_DARKEN: g = (f < b) ? f : b;
        MODE_LIGHTEN: g = (f > b) ? f : b;
        MODE_DIFFERENCE: g = (f > b) ? f - b : b - f;
        MODE_GLOW: begin
          if (f == 8'd255 || quoq[4][c] > 16'd255) begin
            g = 8'd255;
          end else begin
            g = quoq[4][c][7:0];
          end
        end
        MODE_OVERLAY: begin
          if (f < 8'd128) begin
            g = fbq[4][c][14:7];
          end else begin
            g = 8'd255 - invq[4][c][14:7];
          end
        end
        default: g = f;
      endcase
      g6[c] <= g;
      ag6[c] <= 16'(alpha) * 16'(g);
      nb6[c] <= 16'(8'd255 - alpha) * 16'(b);
    end
    b6 <= bq[4];
    for (int c = 0; c < Channels; c++) begin
      if (enable) begin
        r7[c] <= div255(ag6[c] + nb6[c]);
      end else begin
        r7[c] <= b6[c];
      end
    end
  end

  assign out_valid = v7;
  assign result = r7;

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (rst) v1 |-> ##6 v7)
    else $error("layer valid lost");
  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    (v6 && enable && alpha == 8'd0) |=> (r7 == $past(b6)))
    else $error("zero alpha changed backdrop");
  a_noinv: assert property (@(posedge clk) disable iff (rst) !v1 |-> ##6 !v7)
    else $error("layer valid invented");
`endif
endmodule
`default_nettype wire

### sv/three_layer_blend_compositor_unit.sv
// Top level of the three-layer blend compositor.
`default_nettype none
// One pixel transaction per clock: start with busy low is always accepted (busy is
// tied low), and done pulses for one cycle with the composited RGB.
// Each layer is a 7-stage pipeline (products, a four-step radix-16 glow divider,
// blend and alpha mix), and the layers are chained one after another.
// The receiver cannot stall; results must be taken in the cycle that done is high.
module three_layer_blend_compositor_unit
  import tlbc_pkg::*;
#(
  parameter int NUM_LAYERS = DefaultNumLayers
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [7:0] layer0_red,
  input  wire logic [7:0] layer0_green,
  input  wire logic [7:0] layer0_blue,
  input  wire logic [7:0] layer1_red,
  input  wire logic [7:0] layer1_green,
  input  wire logic [7:0] layer1_blue,
  input  wire logic [7:0] layer2_red,
  input  wire logic [7:0] layer2_green,
  input  wire logic [7:0] layer2_blue,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  localparam int Lat = 7;

  logic [HwLayers-1:0][2:0] modes;
  logic [HwLayers-1:0][7:0] alphas;
  pix_t fg_in [HwLayers];
  pix_t fg_d [HwLayers][Lat*HwLayers+1];
  pix_t back [HwLayers+1];
  logic vld [HwLayers+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modes <= '0;
      alphas <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYER0_MODE: modes[0] <= cfg_data[2:0];
        REG_LAYER1_MODE: modes[1] <= cfg_data[2:0];
        REG_LAYER2_MODE: modes[2] <= cfg_data[2:0];
        REG_LAYER0_ALPHA: alphas[0] <= cfg_data;
        REG_LAYER1_ALPHA: alphas[1] <= cfg_data;
        REG_LAYER2_ALPHA: alphas[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fg_in[0] = {layer0_blue, layer0_green, layer0_red};
  assign fg_in[1] = {layer1_blue, layer1_green, layer1_red};
  assign fg_in[2] = {layer2_blue, layer2_green, layer2_red};
  assign back[0] = '0;
  assign vld[0] = start;

  for (genvar i = 0; i < HwLayers; i++) begin : g_layer
    assign fg_d[i][0] = fg_in[i];
    for (genvar k = 0; k < Lat * i; k++) begin : g_dly
      always_ff @(posedge clk) begin
        fg_d[i][k+1] <= fg_d[i][k];
      end
    end
    tlbc_layer u_layer (
      .clk(clk),
      .rst(rst),
      .enable(i < NUM_LAYERS),
      .mode(modes[i]),
      .alpha(alphas[i]),
      .in_valid(vld[i]),
      .fg(fg_d[i][Lat*i]),
      .back(back[i]),
      .out_valid(vld[i+1]),
      .result(back[i+1])
    );
  end

  assign done = vld[HwLayers];
  assign out_red = back[HwLayers][0];
  assign out_green = back[HwLayers][1];
  assign out_blue = back[HwLayers][2];

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##21 done) else $error("transaction result lost");
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(cfg_we) |-> $stable(alphas)) else $error("alpha changed without write");
`endif
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench of the three-layer blend compositor with a directed table and random pixels.
`timescale 1ns / 1ps
module testbench;
  import tlbc_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct {
    rgb_t layer [3];
    logic known;
    rgb_t result;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] layer0_red = '0, layer0_green = '0, layer0_blue = '0;
  logic [7:0] layer1_red = '0, layer1_green = '0, layer1_blue = '0;
  logic [7:0] layer2_red = '0, layer2_green = '0, layer2_blue = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic done;
  logic [7:0] out_red, out_green, out_blue;

  logic [2:0] mode_reg [3];
  logic [7:0] alpha_reg [3];
  rgb_t expected_pixels [$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  pixel_row_t directed_rows [$];

  three_layer_blend_compositor_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .layer0_red(layer0_red), .layer0_green(layer0_green), .layer0_blue(layer0_blue),
    .layer1_red(layer1_red), .layer1_green(layer1_green), .layer1_blue(layer1_blue),
    .layer2_red(layer2_red), .layer2_green(layer2_green), .layer2_blue(layer2_blue),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] blend_byte(input logic [2:0] mode, input logic [7:0] f,
                                            input logic [7:0] b);
    int unsigned fi, bi, q;
    fi = f;
    bi = b;
    case (mode)
      MODE_MULTIPLY: return 8'((fi * bi) >> 8);
      MODE_DARKEN: return (fi < bi) ? f : b;
      MODE_LIGHTEN: return (fi > bi) ? f : b;
      MODE_DIFFERENCE: return (fi > bi) ? 8'(fi - bi) : 8'(bi - fi);
      MODE_GLOW: begin
        if (fi == 255) return 8'd255;
        q = (bi * bi) / (255 - fi);
        return (q > 255) ? 8'd255 : 8'(q);
      end
      MODE_OVERLAY: begin
        if (fi < 128) return 8'((fi * bi) >> 7);
        return 8'(255 - (((255 - fi) * (255 - bi)) >> 7));
      end
      default: return f;
    endcase
  endfunction

  function automatic rgb_t composite_pixel(input rgb_t layer [3]);
    logic [7:0] backdrop [3];
    logic [7:0] fg;
    int unsigned a, g;
    backdrop = '{8'd0, 8'd0, 8'd0};
    for (int i = 0; i < 3; i++) begin
      a = alpha_reg[i];
      for (int c = 0; c < 3; c++) begin
        fg = (c == 0) ? layer[i].red : (c == 1) ? layer[i].green : layer[i].blue;
        g = blend_byte(mode_reg[i], fg, backdrop[c]);
        backdrop[c] = 8'((a * g + (255 - a) * backdrop[c]) / 255);
      end
    end
    return '{backdrop[0], backdrop[1], backdrop[2]};
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx < REG_LAYER0_ALPHA) mode_reg[idx] = val[2:0];
    else if (idx <= REG_LAYER2_ALPHA) alpha_reg[idx - REG_LAYER0_ALPHA] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_layers(input logic [2:0] m0, m1, m2, input logic [7:0] a0, a1, a2);
    write_reg(REG_LAYER0_MODE, 8'(m0));
    write_reg(REG_LAYER1_MODE, 8'(m1));
    write_reg(REG_LAYER2_MODE, 8'(m2));
    write_reg(REG_LAYER0_ALPHA, a0);
    write_reg(REG_LAYER1_ALPHA, a1);
    write_reg(REG_LAYER2_ALPHA, a2);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (expected_pixels.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic send_pixel(input rgb_t layer [3], input logic known, input rgb_t result);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    {layer0_red, layer0_green, layer0_blue} = layer[0];
    {layer1_red, layer1_green, layer1_blue} = layer[1];
    {layer2_red, layer2_green, layer2_blue} = layer[2];
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_pixels.push_back(known ? result : composite_pixel(layer));
  endtask

  task automatic finish_burst;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic rgb_t random_rgb();
    return rgb_t'(24'($urandom));
  endfunction

  task automatic add_row(input rgb_t l0, l1, l2, input logic known, input rgb_t result);
    pixel_row_t row;
    row.layer = '{l0, l1, l2};
    row.known = known;
    row.result = result;
    directed_rows.push_back(row);
  endtask

  initial begin
    rgb_t px [3];
    logic [2:0] m [3];
    logic [7:0] a [3];
    mode_reg = '{3'd0, 3'd0, 3'd0};
    alpha_reg = '{8'd0, 8'd0, 8'd0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row('1, '1, '1, 1'b1, '0);
    add_row(24'h123456, 24'hABCDEF, 24'h00FF80, 1'b1, '0);
    foreach (directed_rows[i]) send_pixel(directed_rows[i].layer, directed_rows[i].known,
                                          directed_rows[i].result);
    finish_burst();
    drain();
    directed_rows.delete();

    set_layers(MODE_NORMAL, MODE_NORMAL, MODE_NORMAL, 8'd255, 8'd0, 8'd0);
    add_row(24'hFF00A5, 24'h123456, 24'h654321, 1'b1, 24'hFF00A5);
    add_row('1, '0, '0, 1'b1, '1);
    add_row('0, '1, '1, 1'b1, '0);
    foreach (directed_rows[i]) send_pixel(directed_rows[i].layer, directed_rows[i].known,
                                          directed_rows[i].result);
    finish_burst();
    drain();
    directed_rows.delete();

    for (int mode = 0; mode < 8; mode++) begin
      set_layers(MODE_NORMAL, 3'(mode), 3'(mode), 8'd255, 8'd255, 8'd128);
      add_row(24'h80FF00, 24'h7F80FF, 24'hFE0001, 1'b0, '0);
      add_row('1, '1, '0, 1'b0, '0);
      add_row('0, 24'hFF7F80, 24'h01FEFF, 1'b0, '0);
      foreach (directed_rows[i]) send_pixel(directed_rows[i].layer, directed_rows[i].known,
                                            directed_rows[i].result);
      finish_burst();
      drain();
      directed_rows.delete();
    end

    write_reg(3'd6, 8'hFF);
    write_reg(3'd7, 8'hFF);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
      for (int setting = 0; setting < 8; setting++) begin
        for (int i = 0; i < 3; i++) begin
          m[i] = 3'($urandom);
          case ($urandom_range(3))
            0: a[i] = 8'd0;
            1: a[i] = 8'd255;
            default: a[i] = 8'($urandom);
          endcase
        end
        set_layers(m[0], m[1], m[2], a[0], a[1], a[2]);
        for (int n = 0; n < 35; n++) begin
          foreach (px[i]) px[i] = random_rgb();
          send_pixel(px, 1'b0, '0);
        end
        finish_burst();
        drain();
      end
    end

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

### files.f
sv/tlbc_pkg.sv
sv/tlbc_layer.sv
sv/three_layer_blend_compositor_unit.sv
verif/testbench.sv
